// ----- rtl/lrs_pkg.sv -----
// shared types and constants of the link reconnect supervisor
`timescale 1ns / 1ps

package lrs_pkg;

    // timer and register widths
    localparam int TIMER_BITS_DEFAULT = 24;
    localparam int CFG_W              = 24;
    localparam int AGE_COUNT          = 5;

    // places of the elapsed-tick counters in the age vector
    localparam int AGE_ATTEMPT    = 0;
    localparam int AGE_RETRY      = 1;
    localparam int AGE_OUTAGE     = 2;
    localparam int AGE_AP_ATTEMPT = 3;
    localparam int AGE_AP_RETRY   = 4;

    // command codes of an input item
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MANUAL = 2'd1;
    localparam logic [1:0] CMD_BOOT   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_RECOVERY = 2'd0;
    localparam logic [1:0] REG_RETRY    = 2'd1;
    localparam logic [1:0] REG_AP_RETRY = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RECOVERY_RESET = 24'd20000;
    localparam logic [CFG_W-1:0] RETRY_RESET    = 24'd5000;
    localparam logic [CFG_W-1:0] AP_RETRY_RESET = 24'd30000;

    // reported codes
    localparam logic [1:0] CONN_IDLE       = 2'd0;
    localparam logic [1:0] CONN_CONNECTING = 2'd1;
    localparam logic [1:0] CONN_CONNECTED  = 2'd2;
    localparam logic [1:0] CONN_RETRY      = 2'd3;
    localparam logic [1:0] PROV_NONE       = 2'd0;
    localparam logic [1:0] PROV_FALLBACK   = 2'd1;
    localparam logic [1:0] PROV_MANUAL     = 2'd2;

    // connection machine
    typedef enum logic [3:0] {
        MS_IDLE       = 4'b0001,
        MS_CONNECTING = 4'b0010,
        MS_CONNECTED  = 4'b0100,
        MS_RETRY      = 4'b1000
    } machine_t;

    // provisioning mode
    typedef enum logic [2:0] {
        PM_NONE     = 3'b001,
        PM_FALLBACK = 3'b010,
        PM_MANUAL   = 3'b100
    } prov_t;

    // control state kept between items
    typedef struct packed {
        machine_t machine;
        prov_t    prov;
        logic     outage_open;
        logic     ap_attempt_open;
        logic     ap_retry_never;
        logic     link_flag;
    } ctl_t;

    // one result item
    typedef struct packed {
        logic [1:0] conn_state;
        logic [1:0] prov_mode;
        logic       start_attempt;
        logic       attempt_with_ap;
        logic       drop_link;
        logic       radio_off;
        logic       start_ap;
        logic       stop_ap;
        logic       link_connected;
    } res_t;

endpackage

// ----- rtl/lrs_core.sv -----
// next-state and result logic for one item of the supervisor
`timescale 1ns / 1ps

module lrs_core
    import lrs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  ctl_t                                 st,
    input  logic [AGE_COUNT-1:0][TIMER_BITS-1:0] ages,
    input  logic [1:0]                           command,
    input  logic                                 link_up,
    input  logic                                 credentials_present,
    input  logic [CFG_W-1:0]                     recovery,
    input  logic [CFG_W-1:0]                     retry_int,
    input  logic [CFG_W-1:0]                     ap_retry_int,
    output ctl_t                                 st_out,
    output logic [AGE_COUNT-1:0][TIMER_BITS-1:0] ages_out,
    output res_t                                 res
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] AGE_MAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] AGE_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

    // saturating increment of an age
    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == AGE_MAX) ? v : v + AGE_ONE;
    endfunction

    // age reached a register limit
    function automatic logic reached(input logic [TIMER_BITS-1:0] age,
                                     input logic [CFG_W-1:0] lim);
        return CMP_W'(age) >= CMP_W'(lim);
    endfunction

    ctl_t                                 n;
    logic [AGE_COUNT-1:0][TIMER_BITS-1:0] a;
    logic o_start, o_with_ap, o_drop, o_off, o_start_ap, o_stop_ap;

    always_comb
    begin
        n          = st;
        a          = ages;
        o_start    = 1'b0;
        o_with_ap  = 1'b0;
        o_drop     = 1'b0;
        o_off      = 1'b0;
        o_start_ap = 1'b0;
        o_stop_ap  = 1'b0;

        priority if (command == CMD_TICK)
        begin
            // time passes first, then the tick is evaluated
            for (int i = 0; i < AGE_COUNT; i++)
            begin
                a[i] = sat_inc(ages[i]);
            end

            if (st.prov != PM_NONE)
            begin
                // provisioning: only fallback with credentials retries
                if (st.prov != PM_MANUAL && credentials_present)
                begin
                    if (link_up)
                    begin
                        n.link_flag       = 1'b1;
                        n.ap_attempt_open = 1'b0;
                        n.prov            = PM_NONE;
                        o_stop_ap         = 1'b1;
                    end
                    else if (st.ap_attempt_open)
                    begin
                        if (reached(a[AGE_AP_ATTEMPT], recovery))
                        begin
                            o_drop            = 1'b1;
                            n.ap_attempt_open = 1'b0;
                        end
                    end
                    else if (st.ap_retry_never || reached(a[AGE_AP_RETRY], ap_retry_int))
                    begin
                        a[AGE_AP_RETRY]   = '0;
                        a[AGE_AP_ATTEMPT] = '0;
                        n.ap_retry_never  = 1'b0;
                        n.ap_attempt_open = 1'b1;
                        o_start           = 1'b1;
                        o_with_ap         = 1'b1;
                    end
                end
            end
            else
            begin
                n.link_flag = link_up;
                if (link_up)
                begin
                    if (st.machine != MS_CONNECTED)
                    begin
                        n.machine     = MS_CONNECTED;
                        n.outage_open = 1'b0;
                    end
                end
                else
                begin
                    unique case (st.machine)
                        MS_IDLE:
                        begin
                            if (credentials_present)
                            begin
                                o_start        = 1'b1;
                                a[AGE_ATTEMPT] = '0;
                                a[AGE_RETRY]   = '0;
                                n.machine      = MS_CONNECTING;
                                if (!st.outage_open)
                                begin
                                    n.outage_open = 1'b1;
                                    a[AGE_OUTAGE] = '0;
                                end
                            end
                        end
                        MS_CONNECTING:
                        begin
                            if (reached(a[AGE_ATTEMPT], recovery))
                            begin
                                o_drop       = 1'b1;
                                n.machine    = MS_RETRY;
                                a[AGE_RETRY] = '0;
                            end
                        end
                        MS_CONNECTED:
                        begin
                            if (!st.outage_open)
                            begin
                                n.outage_open = 1'b1;
                                a[AGE_OUTAGE] = '0;
                            end
                            n.machine    = MS_RETRY;
                            a[AGE_RETRY] = '0;
                        end
                        default:
                        begin
                            // retry wait: outage limit hands over to fallback
                            if (st.outage_open && reached(a[AGE_OUTAGE], recovery))
                            begin
                                o_drop            = 1'b1;
                                o_off             = 1'b1;
                                o_start_ap        = 1'b1;
                                n.prov            = PM_FALLBACK;
                                n.ap_retry_never  = 1'b0;
                                a[AGE_AP_RETRY]   = '0;
                                n.ap_attempt_open = 1'b0;
                                n.machine         = MS_IDLE;
                                n.outage_open     = 1'b0;
                            end
                            else if (reached(a[AGE_RETRY], retry_int))
                            begin
                                if (!credentials_present)
                                begin
                                    n.machine = MS_IDLE;
                                end
                                else
                                begin
                                    o_start        = 1'b1;
                                    a[AGE_ATTEMPT] = '0;
                                    a[AGE_RETRY]   = '0;
                                    n.machine      = MS_CONNECTING;
                                    if (!st.outage_open)
                                    begin
                                        n.outage_open = 1'b1;
                                        a[AGE_OUTAGE] = '0;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
        end
        else if (command == CMD_MANUAL)
        begin
            // manual request (re)starts the access point in manual mode
            if (st.prov != PM_MANUAL)
            begin
                o_stop_ap         = (st.prov != PM_NONE);
                o_start_ap        = 1'b1;
                n.prov            = PM_MANUAL;
                n.ap_retry_never  = 1'b0;
                a[AGE_AP_RETRY]   = '0;
                n.ap_attempt_open = 1'b0;
            end
        end
        else if (command == CMD_BOOT)
        begin
            if (credentials_present)
            begin
                o_start        = 1'b1;
                a[AGE_ATTEMPT] = '0;
                a[AGE_RETRY]   = '0;
                n.machine      = MS_CONNECTING;
                if (!st.outage_open)
                begin
                    n.outage_open = 1'b1;
                    a[AGE_OUTAGE] = '0;
                end
            end
            else if (st.prov != PM_MANUAL)
            begin
                // no credentials: drop the station and go to fallback
                o_drop = 1'b1;
                o_off  = 1'b1;
                if (st.prov == PM_NONE)
                begin
                    o_start_ap        = 1'b1;
                    n.prov            = PM_FALLBACK;
                    n.ap_retry_never  = 1'b0;
                    a[AGE_AP_RETRY]   = '0;
                    n.ap_attempt_open = 1'b0;
                end
            end
        end
        else
        begin
            // unused command: state is only reported
            n = st;
        end
    end

    // result item
    always_comb
    begin
        unique case (n.machine)
            MS_IDLE:       res.conn_state = CONN_IDLE;
            MS_CONNECTING: res.conn_state = CONN_CONNECTING;
            MS_CONNECTED:  res.conn_state = CONN_CONNECTED;
            MS_RETRY:      res.conn_state = CONN_RETRY;
            default:       res.conn_state = CONN_IDLE;
        endcase
        unique case (n.prov)
            PM_NONE:     res.prov_mode = PROV_NONE;
            PM_FALLBACK: res.prov_mode = PROV_FALLBACK;
            PM_MANUAL:   res.prov_mode = PROV_MANUAL;
            default:     res.prov_mode = PROV_NONE;
        endcase
        res.start_attempt   = o_start;
        res.attempt_with_ap = o_start & o_with_ap;
        res.drop_link       = o_drop;
        res.radio_off       = o_drop & o_off;
        res.start_ap        = o_start_ap;
        res.stop_ap         = o_stop_ap;
        res.link_connected  = n.link_flag;
    end

    assign st_out   = n;
    assign ages_out = a;

endmodule

// ----- rtl/lrs_out_buf.sv -----
// two-entry output buffer that keeps the input side moving under stall
`timescale 1ns / 1ps

module lrs_out_buf
    import lrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_data_reg, main_data_next;
    res_t skid_data_reg, skid_data_next;
    logic pop;

    assign pop       = main_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // buffer update
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_data_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/link_reconnect_supervisor.sv -----
// top level of the link reconnect supervisor
`timescale 1ns / 1ps

// Takes one item (tick, manual provisioning request or boot) per clock and
// returns one result item for each, in order. The connection machine, the
// provisioning mode and the five elapsed-tick counters are updated in the
// cycle the item is accepted; the result leaves through a two-entry output
// buffer, so in_ready stays high while its skid entry is free; the sustained
// rate is one item per cycle while results are taken. A result is registered
// in the main entry, or in the skid entry while that is held. Counters are
// TIMER_BITS wide and saturate; a limit wider than them is never reached.
// Configuration writes are always ready and take effect on the next item.

module link_reconnect_supervisor
    import lrs_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       command,
    input  logic             link_up,
    input  logic             credentials_present,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       conn_state,
    output logic [1:0]       prov_mode,
    output logic             start_attempt,
    output logic             attempt_with_ap,
    output logic             drop_link,
    output logic             radio_off,
    output logic             start_ap,
    output logic             stop_ap,
    output logic             link_connected,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam ctl_t CTL_RESET = '{
        machine:         MS_IDLE,
        prov:            PM_NONE,
        outage_open:     1'b0,
        ap_attempt_open: 1'b0,
        ap_retry_never:  1'b1,
        link_flag:       1'b0
    };

    ctl_t                                 ctl_reg, ctl_next;
    logic [AGE_COUNT-1:0][TIMER_BITS-1:0] ages_reg, ages_next;
    logic [CFG_W-1:0] recovery_reg, retry_reg, ap_retry_reg;
    res_t res;
    res_t out_res;
    logic in_fire;
    logic cfg_fire;

    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recovery_reg <= RECOVERY_RESET;
            retry_reg    <= RETRY_RESET;
            ap_retry_reg <= AP_RETRY_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_RECOVERY: recovery_reg <= cfg_data;
                REG_RETRY:    retry_reg    <= cfg_data;
                REG_AP_RETRY: ap_retry_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // per-item state update
    lrs_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .st                  (ctl_reg),
        .ages                (ages_reg),
        .command             (command),
        .link_up             (link_up),
        .credentials_present (credentials_present),
        .recovery            (recovery_reg),
        .retry_int           (retry_reg),
        .ap_retry_int        (ap_retry_reg),
        .st_out              (ctl_next),
        .ages_out            (ages_next),
        .res                 (res)
    );

    // supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= CTL_RESET;
            ages_reg <= '0;
        end
        else if (in_fire)
        begin
            ctl_reg  <= ctl_next;
            ages_reg <= ages_next;
        end
    end

    // result buffering
    lrs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign conn_state      = out_res.conn_state;
    assign prov_mode       = out_res.prov_mode;
    assign start_attempt   = out_res.start_attempt;
    assign attempt_with_ap = out_res.attempt_with_ap;
    assign drop_link       = out_res.drop_link;
    assign radio_off       = out_res.radio_off;
    assign start_ap        = out_res.start_ap;
    assign stop_ap         = out_res.stop_ap;
    assign link_connected  = out_res.link_connected;

    // checks
    a_with_ap_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && attempt_with_ap |-> start_attempt)
        else $error("attempt_with_ap without start_attempt");

    a_off_needs_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radio_off |-> drop_link)
        else $error("radio_off without drop_link");

    a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_manual_holds_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && command == CMD_TICK && ctl_reg.prov == PM_MANUAL
        |=> ctl_reg.prov == PM_MANUAL)
        else $error("tick left manual provisioning");

endmodule

// ----- dv/link_reconnect_supervisor_test.sv -----
// self-checking testbench for the link reconnect supervisor
`timescale 1ns / 1ps

module link_reconnect_supervisor_test;
    import lrs_pkg::*;

    localparam int AGE_W        = TIMER_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 260;
    localparam int TAIL_ITEMS   = 100;
    localparam int LONG_HOLD    = 80;
    localparam int QUIET_ITEMS  = 120;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [AGE_W-1:0] AGE_TOP = '1;

    // one line of the directed plan: an item or a register write
    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
    typedef struct packed {
        row_kind_t        kind;
        logic [1:0]       code;
        logic             up;
        logic             cred;
        logic [CFG_W-1:0] data;
        logic             typed;
        res_t             want;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       command;
    logic             link_up;
    logic             credentials_present;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       conn_state;
    logic [1:0]       prov_mode;
    logic             start_attempt;
    logic             attempt_with_ap;
    logic             drop_link;
    logic             radio_off;
    logic             start_ap;
    logic             stop_ap;
    logic             link_connected;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // supervisor image kept by the testbench
    logic [CFG_W-1:0] recovery_lim, retry_lim, ap_retry_lim;
    logic [1:0]       conn_code, prov_code;
    logic [AGE_W-1:0] try_ticks, wait_ticks, down_ticks, ap_try_ticks, ap_gap_ticks;
    logic             down_open, ap_try_open, ap_first, linked;
    logic             fire_start, fire_with_ap, fire_drop, fire_off, fire_start_ap, fire_stop_ap;

    res_t      pending_results[$];
    plan_row_t stimulus_plan[$];
    int        mismatch_count = 0;
    int        quiet_items = 0;
    bit        steady_tail = 1'b0;
    bit        want_long_hold = 1'b0;

    link_reconnect_supervisor dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // elapsed tick counter, saturating
    function automatic logic [AGE_W-1:0] bump_age(input logic [AGE_W-1:0] a);
        return (a == AGE_TOP) ? a : a + 1'b1;
    endfunction

    // station attempt, or idle without credentials
    task automatic launch_attempt(input logic cred);
        if (!cred)
        begin
            conn_code = CONN_IDLE;
        end
        else
        begin
            fire_start   = 1'b1;
            fire_with_ap = 1'b0;
            try_ticks    = '0;
            wait_ticks   = '0;
            conn_code    = CONN_CONNECTING;
            if (!down_open)
            begin
                down_open  = 1'b1;
                down_ticks = '0;
            end
        end
    endtask

    task automatic raise_ap(input logic [1:0] mode);
        if (prov_code == PROV_NONE)
        begin
            fire_start_ap = 1'b1;
            prov_code     = mode;
            ap_first      = 1'b0;
            ap_gap_ticks  = '0;
            ap_try_open   = 1'b0;
        end
    endtask

    task automatic lower_ap();
        if (prov_code != PROV_NONE)
        begin
            fire_stop_ap = 1'b1;
            prov_code    = PROV_NONE;
            ap_try_open  = 1'b0;
        end
    endtask

    // fallback provisioning, never over manual mode
    task automatic fall_back();
        if (prov_code != PROV_MANUAL)
        begin
            fire_drop = 1'b1;
            fire_off  = 1'b1;
            raise_ap(PROV_FALLBACK);
        end
    endtask

    // expected result of one item, updating the image
    task automatic advance_supervisor(input logic [1:0] cmd, input logic up, input logic cred,
                                      output res_t r);
        fire_start    = 1'b0;
        fire_with_ap  = 1'b0;
        fire_drop     = 1'b0;
        fire_off      = 1'b0;
        fire_start_ap = 1'b0;
        fire_stop_ap  = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                try_ticks    = bump_age(try_ticks);
                wait_ticks   = bump_age(wait_ticks);
                down_ticks   = bump_age(down_ticks);
                ap_try_ticks = bump_age(ap_try_ticks);
                ap_gap_ticks = bump_age(ap_gap_ticks);
                if (prov_code != PROV_NONE)
                begin
                    // fallback retries the saved network; manual waits
                    if (prov_code == PROV_FALLBACK && cred)
                    begin
                        if (up)
                        begin
                            linked      = 1'b1;
                            ap_try_open = 1'b0;
                            lower_ap();
                        end
                        else if (ap_try_open)
                        begin
                            if (ap_try_ticks >= recovery_lim)
                            begin
                                fire_drop   = 1'b1;
                                fire_off    = 1'b0;
                                ap_try_open = 1'b0;
                            end
                        end
                        else if (ap_first || ap_gap_ticks >= ap_retry_lim)
                        begin
                            ap_gap_ticks = '0;
                            ap_first     = 1'b0;
                            ap_try_ticks = '0;
                            ap_try_open  = 1'b1;
                            fire_start   = 1'b1;
                            fire_with_ap = 1'b1;
                        end
                    end
                end
                else
                begin
                    linked = up;
                    if (up)
                    begin
                        if (conn_code != CONN_CONNECTED)
                        begin
                            conn_code = CONN_CONNECTED;
                            down_open = 1'b0;
                        end
                    end
                    else
                    begin
                        case (conn_code)
                            CONN_IDLE:
                            begin
                                if (cred)
                                    launch_attempt(cred);
                            end
                            CONN_CONNECTING:
                            begin
                                if (try_ticks >= recovery_lim)
                                begin
                                    fire_drop  = 1'b1;
                                    fire_off   = 1'b0;
                                    conn_code  = CONN_RETRY;
                                    wait_ticks = '0;
                                end
                            end
                            CONN_CONNECTED:
                            begin
                                if (!down_open)
                                begin
                                    down_open  = 1'b1;
                                    down_ticks = '0;
                                end
                                conn_code  = CONN_RETRY;
                                wait_ticks = '0;
                            end
                            default:
                            begin
                                // outage too long hands over to fallback
                                if (down_open && down_ticks >= recovery_lim)
                                begin
                                    fall_back();
                                    conn_code = CONN_IDLE;
                                    down_open = 1'b0;
                                end
                                else if (wait_ticks >= retry_lim)
                                begin
                                    launch_attempt(cred);
                                end
                            end
                        endcase
                    end
                end
            end
            CMD_MANUAL:
            begin
                if (prov_code != PROV_MANUAL)
                begin
                    lower_ap();
                    raise_ap(PROV_MANUAL);
                end
            end
            CMD_BOOT:
            begin
                if (cred)
                    launch_attempt(cred);
                else
                    fall_back();
            end
            default: ;
        endcase
        r = {conn_code, prov_code, fire_start, fire_start & fire_with_ap, fire_drop,
             fire_drop & fire_off, fire_start_ap, fire_stop_ap, linked};
    endtask

    // plan rows
    function automatic res_t make_result(input logic [1:0] conn, input logic [1:0] prov,
                                         input logic [5:0] strobes, input logic link);
        return {conn, prov, strobes, link};
    endfunction

    function automatic plan_row_t item_row(input logic [1:0] cmd, input logic up,
                                           input logic cred);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.code = cmd;
        r.up   = up;
        r.cred = cred;
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic [1:0] cmd, input logic up,
                                            input logic cred, input res_t want);
        plan_row_t r;
        r       = item_row(cmd, up, cred);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [1:0] idx,
                                            input logic [CFG_W-1:0] value);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.code = idx;
        r.data = value;
        return r;
    endfunction

    // register limits for a random phase, extremes now and then
    function automatic logic [CFG_W-1:0] pick_limit(input int span);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return CFG_W'(1);
        return CFG_W'($urandom_range(2, span));
    endfunction

    // offer one item, hold it until taken, then queue its expected result
    task automatic offer_item(input logic [1:0] cmd, input logic up, input logic cred,
                              input logic typed, input res_t want);
        res_t forecast;
        command             <= cmd;
        link_up             <= up;
        credentials_present <= cred;
        in_valid            <= 1'b1;
        do @(posedge clk); while (!in_ready);
        advance_supervisor(cmd, up, cred, forecast);
        pending_results.push_back(typed ? want : forecast);
        if (!steady_tail && quiet_items == 0 && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        if (quiet_items != 0)
            quiet_items--;
    endtask

    // register write once every result is back
    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RECOVERY: recovery_lim = value;
            REG_RETRY:    retry_lim    = value;
            REG_AP_RETRY: ap_retry_lim = value;
            default: ;
        endcase
    endtask

    task automatic walk_plan();
        foreach (stimulus_plan[i])
        begin
            if (stimulus_plan[i].kind == ROW_WRITE)
                write_register(stimulus_plan[i].code, stimulus_plan[i].data);
            else
                offer_item(stimulus_plan[i].code, stimulus_plan[i].up, stimulus_plan[i].cred,
                           stimulus_plan[i].typed, stimulus_plan[i].want);
        end
        stimulus_plan.delete();
    endtask

    task automatic compare_field(input string name, input logic [1:0] want,
                                 input logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_long_hold)
            begin
                hold_left      = LONG_HOLD;
                want_long_hold = 1'b0;
            end
            else if (hold_left == 0 && !steady_tail && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 3);
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {conn_state, prov_mode, start_attempt, attempt_with_ap, drop_link, radio_off,
                   start_ap, stop_ap, link_connected};
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: %b", got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("conn_state", want.conn_state, got.conn_state);
                compare_field("prov_mode", want.prov_mode, got.prov_mode);
                compare_field("start_attempt", want.start_attempt, got.start_attempt);
                compare_field("attempt_with_ap", want.attempt_with_ap, got.attempt_with_ap);
                compare_field("drop_link", want.drop_link, got.drop_link);
                compare_field("radio_off", want.radio_off, got.radio_off);
                compare_field("start_ap", want.start_ap, got.start_ap);
                compare_field("stop_ap", want.stop_ap, got.stop_ap);
                compare_field("link_connected", want.link_connected, got.link_connected);
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("link_reconnect_supervisor_test failed");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int         phase;
        int         sent;
        int         run_len;
        int         roll;
        logic [1:0] cmd;
        logic       up_level;
        logic       cred_level;
        logic       up_bit;

        rst_n               <= 1'b0;
        in_valid            <= 1'b0;
        command             <= CMD_TICK;
        link_up             <= 1'b0;
        credentials_present <= 1'b0;
        cfg_valid           <= 1'b0;
        cfg_index           <= REG_RECOVERY;
        cfg_data            <= '0;

        // image at reset
        recovery_lim = RECOVERY_RESET;
        retry_lim    = RETRY_RESET;
        ap_retry_lim = AP_RETRY_RESET;
        conn_code    = CONN_IDLE;
        prov_code    = PROV_NONE;
        try_ticks    = '0;
        wait_ticks   = '0;
        down_ticks   = '0;
        ap_try_ticks = '0;
        ap_gap_ticks = '0;
        down_open    = 1'b0;
        ap_try_open  = 1'b0;
        ap_first     = 1'b1;
        linked       = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values, tick, boot, unused, timeouts at register extremes
        stimulus_plan.push_back(typed_row(CMD_UNUSED, 1'b1, 1'b1,
                                make_result(CONN_IDLE, PROV_NONE, 6'b000000, 1'b0)));
        stimulus_plan.push_back(typed_row(CMD_TICK, 1'b0, 1'b0,
                                make_result(CONN_IDLE, PROV_NONE, 6'b000000, 1'b0)));
        stimulus_plan.push_back(typed_row(CMD_TICK, 1'b0, 1'b1,
                                make_result(CONN_CONNECTING, PROV_NONE, 6'b100000, 1'b0)));
        stimulus_plan.push_back(typed_row(CMD_TICK, 1'b1, 1'b1,
                                make_result(CONN_CONNECTED, PROV_NONE, 6'b000000, 1'b1)));
        stimulus_plan.push_back(typed_row(CMD_TICK, 1'b0, 1'b1,
                                make_result(CONN_RETRY, PROV_NONE, 6'b000000, 1'b0)));
        stimulus_plan.push_back(typed_row(CMD_BOOT, 1'b0, 1'b1,
                                make_result(CONN_CONNECTING, PROV_NONE, 6'b100000, 1'b0)));
        stimulus_plan.push_back(typed_row(CMD_BOOT, 1'b1, 1'b0,
                                make_result(CONN_CONNECTING, PROV_FALLBACK, 6'b001110, 1'b0)));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b1, 1'b0));
        stimulus_plan.push_back(typed_row(CMD_TICK, 1'b1, 1'b1,
                                make_result(CONN_CONNECTING, PROV_NONE, 6'b000001, 1'b1)));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(write_row(REG_RECOVERY, CFG_W'(1)));
        stimulus_plan.push_back(write_row(REG_RETRY, CFG_W'(1)));
        stimulus_plan.push_back(write_row(REG_AP_RETRY, CFG_W'(1)));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b1, 1'b1));
        stimulus_plan.push_back(write_row(REG_UNUSED, CFG_W'(7)));
        stimulus_plan.push_back(write_row(REG_RECOVERY, '0));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b1, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b1, 1'b1));
        stimulus_plan.push_back(write_row(REG_RECOVERY, '1));
        stimulus_plan.push_back(write_row(REG_RETRY, '1));
        stimulus_plan.push_back(write_row(REG_AP_RETRY, '1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_BOOT, 1'b0, 1'b0));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        walk_plan();

        // random phases: link level and credentials held over runs of ticks
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_register(REG_RECOVERY, pick_limit(40));
            write_register(REG_RETRY, pick_limit(12));
            write_register(REG_AP_RETRY, pick_limit(30));
            if (phase == 1)
            begin
                want_long_hold = 1'b1;
                quiet_items    = QUIET_ITEMS;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len    = $urandom_range(1, 30);
                up_level   = ($urandom_range(0, 99) < 40);
                cred_level = ($urandom_range(0, 99) < 88);
                for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4)
                        cmd = CMD_BOOT;
                    else if (roll < 6)
                        cmd = CMD_UNUSED;
                    else
                        cmd = CMD_TICK;
                    up_bit = up_level;
                    if ($urandom_range(0, 19) == 0)
                        up_bit = ~up_level;
                    offer_item(cmd, up_bit, cred_level, 1'b0, '0);
                    sent++;
                end
            end
        end

        // closing part, no idling: manual mode is left only by reset
        steady_tail = 1'b1;
        stimulus_plan.push_back(write_row(REG_RECOVERY, CFG_W'(2)));
        stimulus_plan.push_back(write_row(REG_RETRY, CFG_W'(1)));
        stimulus_plan.push_back(write_row(REG_AP_RETRY, CFG_W'(3)));
        stimulus_plan.push_back(item_row(CMD_BOOT, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_BOOT, 1'b0, 1'b0));
        stimulus_plan.push_back(item_row(CMD_MANUAL, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_MANUAL, 1'b1, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b0, 1'b1));
        stimulus_plan.push_back(item_row(CMD_TICK, 1'b1, 1'b1));
        stimulus_plan.push_back(item_row(CMD_BOOT, 1'b0, 1'b0));
        stimulus_plan.push_back(item_row(CMD_BOOT, 1'b1, 1'b1));
        stimulus_plan.push_back(item_row(CMD_UNUSED, 1'b0, 1'b0));
        walk_plan();
        for (sent = 0; sent < TAIL_ITEMS; sent++)
        begin
            cmd = 2'($urandom_range(0, 3));
            offer_item(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end

        // drain and settle
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("link_reconnect_supervisor_test passed");
        else
            $display("link_reconnect_supervisor_test failed");
        $finish;
    end

endmodule
